>>> src/phrt_pkg.sv
// ----------------------------------------------------------------------------
// phrt_pkg - shared definitions for the path hash reference count table
// Field widths, table geometry, hash constants, status codes and the
// control types passed between the top level and the hash accumulator.
// ----------------------------------------------------------------------------
package phrt_pkg;

	// Input and output field widths
	localparam int CHAR_W   = 8;
	localparam int STATUS_W = 3;

	// Running hash
	localparam int              HASH_W     = 64;
	localparam int              HASH_SHIFT = 5;
	localparam logic [HASH_W-1:0] HASH_SEED = HASH_W'(5381);

	// Slot table: a power of two, so the start slot is the low hash bits
	localparam int SLOT_W      = 11;
	localparam int TABLE_SLOTS = 2 ** SLOT_W;

	// Asset pool
	localparam int POOL_ENTRIES = 1024;
	localparam int POOL_W       = $clog2(POOL_ENTRIES);
	localparam int FILL_W       = $clog2(POOL_ENTRIES + 1);

	// Reference counts
	localparam int                    COUNT_BITS = 16;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

	// Command codes
	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_FOUND    = 3'd0,
		STAT_INSERTED = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_RELEASED = 3'd3,
		STAT_ZERO     = 3'd4,
		STAT_UNUSED   = 3'd5
	} status_t;

	// One slot of the open-addressing table
	typedef struct packed {
		logic              valid;
		logic [HASH_W-1:0] hash;
		logic [POOL_W-1:0] index;
	} slot_t;

	// Controller states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ISSUE,
		S_PROBE,
		S_CNT_RD,
		S_CNT_UPD,
		S_EMIT
	} state_t;

	// Hash accumulator control
	typedef struct packed {
		logic fold;     // fold the current character in
		logic restart;  // return to the seed after folding
	} hash_ctl_t;

endpackage

>>> src/phrt_hash.sv
// ----------------------------------------------------------------------------
// phrt_hash - running djb2 hash accumulator
// Holds the hash of the path so far and presents hash * 33 + char for the
// character on the input; folds it in or restarts from the seed on command.
// ----------------------------------------------------------------------------
module phrt_hash (
	input  logic                          clk,
	input  logic                          arst_n,
	input  phrt_pkg::hash_ctl_t           ctl,
	input  logic [phrt_pkg::CHAR_W-1:0]   path_char,
	output logic [phrt_pkg::HASH_W-1:0]   hash_next
);
	import phrt_pkg::*;

	logic [HASH_W-1:0] hash_q;

	// hash * 33 + char, modulo 2^64
	assign hash_next = {hash_q[HASH_W-1-HASH_SHIFT:0], HASH_SHIFT'(0)} + hash_q
		+ HASH_W'(path_char);

	// Running hash register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_SEED;
		end else if (ctl.fold) begin
			if (ctl.restart) begin
				hash_q <= HASH_SEED;
			end else begin
				hash_q <= hash_next;
			end
		end
	end

endmodule

>>> src/path_hash_refcount_table.sv
// ----------------------------------------------------------------------------
// path_hash_refcount_table - asset path lookup with reference counts
// Hashes path characters, probes an open-addressing slot table and keeps a
// saturating reference count per pool entry.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): command, path_char, last_char,
//   release_index. Output channel (out_valid/out_stall): status, asset_id,
//   use_count. A transaction moves on a clock edge with valid high, stall low.
//   Path characters that are not last are taken one per cycle while in_stall is low, no result.
//   A last character goes via the issue and probe states to its result on an
//   insert or full pool, and on a hit via count read and update too; the
//   linear probe walks one slot per cycle via the single slot memory read
//   port. A release goes via the count read and update, or straight to its
//   result if the index is not in use; the count memory is read, then
//   written back if the count changes. Only one result-producing transaction
//   is in flight; in_stall stays high until its result has entered the
//   output register. After reset the slot table, all 2048 slots, is swept
//   clear, one slot per cycle, with in_stall high. A stalled result holds
//   in the output register; the input stays open until the next
//   result-producing transaction is taken, whose result then waits in the
//   controller, with in_stall high, until the register frees.
// ----------------------------------------------------------------------------
module path_hash_refcount_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              command,
	input  logic [phrt_pkg::CHAR_W-1:0]       path_char,
	input  logic                              last_char,
	input  logic [phrt_pkg::POOL_W-1:0]       release_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [phrt_pkg::STATUS_W-1:0]     status,
	output logic [phrt_pkg::POOL_W-1:0]       asset_id,
	output logic [phrt_pkg::COUNT_BITS-1:0]   use_count
);
	import phrt_pkg::*;

	state_t state_q, state_d;

	logic                  in_acc;
	logic                  out_free;
	hash_ctl_t             hash_ctl;
	logic [HASH_W-1:0]     hash_next;

	logic [SLOT_W-1:0]     clr_q;
	logic [FILL_W-1:0]     pool_fill_q;
	logic                  pool_full;
	logic                  rel_unused;

	logic [HASH_W-1:0]     probe_hash_q;
	logic [SLOT_W-1:0]     pos_q;
	logic [SLOT_W-1:0]     probe_n_q;
	logic [POOL_W-1:0]     idx_q;
	logic                  dec_q;

	// Slot memory
	slot_t                 slot_mem [TABLE_SLOTS];
	slot_t                 slot_rdata_q;
	logic                  slot_we, slot_re;
	logic [SLOT_W-1:0]     slot_wa, slot_ra;
	slot_t                 slot_wd;

	// Count memory
	logic [COUNT_BITS-1:0] cnt_mem [POOL_ENTRIES];
	logic [COUNT_BITS-1:0] cnt_rdata_q;
	logic                  cnt_we, cnt_re;
	logic [POOL_W-1:0]     cnt_wa, cnt_ra;
	logic [COUNT_BITS-1:0] cnt_wd;

	// Pending result
	logic                  res_ld;
	status_t               res_stat_d, res_stat_q;
	logic [POOL_W-1:0]     res_idx_d, res_idx_q;
	logic [COUNT_BITS-1:0] res_cnt_d, res_cnt_q;

	// Output register
	logic                  out_valid_q;
	status_t               status_q;
	logic [POOL_W-1:0]     asset_id_q;
	logic [COUNT_BITS-1:0] use_count_q;
	logic                  out_load;

	logic                  probe_hit;
	logic                  probe_last;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == S_EMIT) && out_free;

	assign pool_full  = (pool_fill_q == FILL_W'(POOL_ENTRIES));
	assign rel_unused = (FILL_W'(release_index) >= pool_fill_q);
	assign probe_hit  = slot_rdata_q.valid && (slot_rdata_q.hash == probe_hash_q);
	assign probe_last = (probe_n_q == SLOT_W'(TABLE_SLOTS - 1));

	// Hash accumulator
	assign hash_ctl.fold    = in_acc && (command == CMD_LOAD);
	assign hash_ctl.restart = last_char;

	phrt_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (hash_ctl),
		.path_char (path_char),
		.hash_next (hash_next)
	);

	// Slot memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
		if (slot_re) begin
			slot_rdata_q <= slot_mem[slot_ra];
		end
	end

	// Count memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (cnt_re) begin
			cnt_rdata_q <= cnt_mem[cnt_ra];
		end
	end

	// Next state, memory controls and result
	always_comb begin
		state_d    = state_q;
		slot_we    = 1'b0;
		slot_wa    = pos_q;
		slot_wd    = '0;
		slot_re    = 1'b0;
		slot_ra    = pos_q;
		cnt_we     = 1'b0;
		cnt_wa     = idx_q;
		cnt_wd     = '0;
		cnt_re     = 1'b0;
		cnt_ra     = idx_q;
		res_ld     = 1'b0;
		res_stat_d = STAT_FULL;
		res_idx_d  = '0;
		res_cnt_d  = '0;
		unique case (state_q)
			S_CLEAR: begin
				slot_we = 1'b1;
				slot_wa = clr_q;
				if (clr_q == SLOT_W'(TABLE_SLOTS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_acc && (command == CMD_LOAD) && last_char) begin
					state_d = S_ISSUE;
				end else if (in_acc && (command == CMD_RELEASE)) begin
					if (rel_unused) begin
						res_ld     = 1'b1;
						res_stat_d = STAT_UNUSED;
						res_idx_d  = release_index;
						state_d    = S_EMIT;
					end else begin
						state_d = S_CNT_RD;
					end
				end
			end
			S_ISSUE: begin
				slot_re = 1'b1;
				state_d = S_PROBE;
			end
			S_PROBE: begin
				if (!slot_rdata_q.valid) begin
					res_ld  = 1'b1;
					state_d = S_EMIT;
					if (!pool_full) begin
						slot_we       = 1'b1;
						slot_wd.valid = 1'b1;
						slot_wd.hash  = probe_hash_q;
						slot_wd.index = pool_fill_q[POOL_W-1:0];
						cnt_we        = 1'b1;
						cnt_wa        = pool_fill_q[POOL_W-1:0];
						cnt_wd        = COUNT_BITS'(1);
						res_stat_d    = STAT_INSERTED;
						res_idx_d     = pool_fill_q[POOL_W-1:0];
						res_cnt_d     = COUNT_BITS'(1);
					end
				end else if (probe_hit) begin
					state_d = S_CNT_RD;
				end else if (probe_last) begin
					// walked the whole table without a match or a free slot
					res_ld  = 1'b1;
					state_d = S_EMIT;
				end else begin
					slot_re = 1'b1;
					slot_ra = pos_q + 1'b1;
				end
			end
			S_CNT_RD: begin
				cnt_re  = 1'b1;
				state_d = S_CNT_UPD;
			end
			S_CNT_UPD: begin
				res_ld    = 1'b1;
				res_idx_d = idx_q;
				state_d   = S_EMIT;
				if (dec_q) begin
					if (cnt_rdata_q == '0) begin
						res_stat_d = STAT_ZERO;
					end else begin
						cnt_we     = 1'b1;
						cnt_wd     = cnt_rdata_q - 1'b1;
						res_stat_d = STAT_RELEASED;
						res_cnt_d  = cnt_rdata_q - 1'b1;
					end
				end else begin
					res_stat_d = STAT_FOUND;
					if (cnt_rdata_q != COUNT_MAX) begin
						cnt_we    = 1'b1;
						cnt_wd    = cnt_rdata_q + 1'b1;
						res_cnt_d = cnt_rdata_q + 1'b1;
					end else begin
						res_cnt_d = cnt_rdata_q;
					end
				end
			end
			S_EMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			pool_fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if ((state_q == S_PROBE) && !slot_rdata_q.valid && !pool_full) begin
				pool_fill_q <= pool_fill_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Probe and operation registers
	always_ff @(posedge clk) begin
		if (in_acc && (command == CMD_LOAD) && last_char) begin
			probe_hash_q <= hash_next;
			pos_q        <= hash_next[SLOT_W-1:0];
			probe_n_q    <= '0;
		end
		if (in_acc && (command == CMD_RELEASE)) begin
			idx_q <= release_index;
			dec_q <= 1'b1;
		end
		if ((state_q == S_PROBE) && probe_hit) begin
			idx_q <= slot_rdata_q.index;
			dec_q <= 1'b0;
		end
		if ((state_q == S_PROBE) && slot_rdata_q.valid && !probe_hit) begin
			pos_q     <= pos_q + 1'b1;
			probe_n_q <= probe_n_q + 1'b1;
		end
	end

	// Pending result and output payload
	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_stat_q <= res_stat_d;
			res_idx_q  <= res_idx_d;
			res_cnt_q  <= res_cnt_d;
		end
		if (out_load) begin
			status_q    <= res_stat_q;
			asset_id_q  <= res_idx_q;
			use_count_q <= res_cnt_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign asset_id  = asset_id_q;
	assign use_count = use_count_q;

	// Assertions
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pool_fill_q <= FILL_W'(POOL_ENTRIES))
		else $error("pool fill beyond pool size");

	a_slot_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(slot_we && slot_re))
		else $error("slot memory read and written in one cycle");

	a_cnt_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CNT_UPD) |-> ($past(state_q) == S_CNT_RD))
		else $error("count update without a preceding count read");

	a_insert_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE && !slot_rdata_q.valid && !pool_full)
		|=> (pool_fill_q == $past(pool_fill_q) + 1'b1))
		else $error("insert did not advance pool fill");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (in_stall && !out_load))
		else $error("activity during the clearing pass");

endmodule
